// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the jitter buffer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define AJB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define AJB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ajb_pkg.sv -----
// Types and constants for the adaptive jitter buffer
package ajb_pkg;

  localparam int DIV_AW     = 32;
  localparam int DIV_BW     = 16;
  localparam int LEN_W      = 11;
  localparam int SLOT_IDX_W = 6;

  localparam logic [15:0] RST_FRAME = 16'd20;
  localparam logic [15:0] RST_MIN   = 16'd20;
  localparam logic [15:0] RST_MAX   = 16'd200;
  localparam logic [15:0] RST_HOLD  = 16'd50;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_PULL    = 2'd1,
    ACT_DRAIN   = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_LATE  = 3'd1,
    STS_FULL  = 3'd2,
    STS_LOST  = 3'd3,
    STS_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_FRAME = 2'd0,
    REG_MIN   = 2'd1,
    REG_MAX   = 2'd2,
    REG_HOLD  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] seq;
    logic [31:0] media_time;
    logic [15:0] length;
    logic [31:0] arrival_time;
    logic [7:0]  max_count;
  } in_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [LEN_W-1:0]      out_length;
    logic [31:0]           out_seq;
    logic [15:0]           jitter_int;
    logic [15:0]           target_delay;
    logic                  burst_loss;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic [15:0] frame;
    logic [15:0] min_delay;
    logic [15:0] max_delay;
    logic [15:0] hold;
  } cfg_t;

  typedef struct packed {
    logic [31:0] jitter_nxt;
    logic [15:0] target_nxt;
    logic [15:0] stable_nxt;
  } est_t;

endpackage

// ----- rtl/core/adaptive_jitter_buffer.sv -----
// Top level of the adaptive jitter buffer: sequencer, slot and NACK memories
// Usage:
// Input channel in_valid/in_ready/in_data carries one command per transfer
// (push, pull, drain, restart). Results leave on out_valid/out_ready/out_result,
// one transfer each; out_result.last marks the final result of a command.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Packet state lives in a SLOTS-entry slot RAM addressed by the low seq bits;
// lost sequence numbers in a NACK_DEPTH-entry RAM. A serial divider
// forms the start threshold target/frame.
// A push reads and checks its slot, then updates jitter and target delay (a
// rejected push emits after the check); before playout it also divides (not
// with zero frame), scans every slot of the slot RAM and decides on start. A
// pull reads and checks the play slot (emits at once before playout); a drain
// reads and emits each returned entry; a restart clears. in_ready rises with
// result valid, so one command is in flight at a time. Reset and restart both
// run a clearing pass over the slot RAM, during which in_ready is low. A result
// register holds the last result, so the next command is taken while it waits;
// if the receiver stalls, the one after holds at its result until out_ready.
`include "assert_macros.svh"
module adaptive_jitter_buffer #(
  parameter int SLOTS       = 64,
  parameter int MAX_PAYLOAD = 1500,
  parameter int NACK_DEPTH  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ajb_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ajb_pkg::out_t  out_result,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import ajb_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int CNW = $clog2(SLOTS + 1);
  localparam int NIW = (NACK_DEPTH > 1) ? $clog2(NACK_DEPTH) : 1;
  localparam int NFW = $clog2(NACK_DEPTH + 1);
  localparam int MW  = 1 + 32 + LEN_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR, ST_PRD, ST_PCHK, ST_JIT, ST_DLY,
    ST_FRM, ST_FRMW, ST_SCAN, ST_SEND, ST_START, ST_LRD, ST_LCHK,
    ST_DRD, ST_DEM, ST_EMIT
  } state_t;

  state_t state_r;
  cfg_t   cfg_r;
  in_t    in_r;
  out_t   out_r;
  logic   out_valid_r;

  logic [SW-1:0]    clr_a_r;
  logic             clr_emit_r;
  logic [SW-1:0]    slot_r;
  logic             playing_r;
  logic [31:0]      play_seq_r;
  logic [SW-1:0]    play_slot_r;
  logic [15:0]      delay_target_r;
  logic [31:0]      jitter_r;
  logic [31:0]      prev_arrival_r;
  logic [31:0]      prev_transit_r;
  logic [NFW-1:0]   nack_fill_r;
  logic [15:0]      lost_run_r;
  logic [15:0]      stable_run_r;
  logic [15:0]      frames_r;
  logic [SW-1:0]    scan_a_r;
  logic [SW-1:0]    scan_di_r;
  logic             scan_dv_r;
  logic [CNW-1:0]   depth_r;
  logic             any_r;
  logic [31:0]      lo_r;
  logic [SW-1:0]    lo_slot_r;
  logic [NFW-1:0]   dr_n_r;
  logic [NFW-1:0]   dr_i_r;

  status_t          res_status_r;
  logic [SW-1:0]    res_slot_r;
  logic [LEN_W-1:0] res_len_r;
  logic [31:0]      res_seq_r;

  logic            s_we, s_re;
  logic [SW-1:0]   s_wa, s_ra;
  logic [MW-1:0]   s_wd, s_rd;
  logic            n_we, n_re;
  logic [NIW-1:0]  n_wa, n_ra;
  logic [31:0]     n_wd, n_rd;

  logic              div_start, div_busy, div_done;
  logic [DIV_AW-1:0] div_a, div_q;
  logic [DIV_BW-1:0] div_b;

  logic             q_used;
  logic [31:0]      q_seq;
  logic [LEN_W-1:0] q_len;
  logic             too_big, late, coll, hit, out_free, emit_go;
  logic [31:0]      transit;
  logic [7:0]       fill8;
  logic [7:0]       drain_n;
  logic [15:0]      res_slot16;
  logic [31:0]      play_seq_inc;
  logic [SW-1:0]    play_slot_inc;
  est_t             est;

  assign {q_used, q_seq, q_len} = s_rd;
  assign too_big  = in_r.length > 16'(MAX_PAYLOAD);
  assign late     = playing_r && (in_r.seq < play_seq_r);
  assign coll     = q_used && (q_seq != in_r.seq) && (q_seq >= play_seq_r);
  assign hit      = q_used && (q_seq == play_seq_r);
  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = ((state_r == ST_EMIT) || (state_r == ST_DEM)) && out_free;
  assign transit  = in_r.arrival_time - in_r.media_time;
  assign fill8    = 8'(nack_fill_r);
  assign drain_n  = (fill8 < in_data.max_count) ? fill8 : in_data.max_count;
  assign res_slot16 = 16'(res_slot_r);
  assign play_seq_inc  = play_seq_r + 32'd1;
  assign play_slot_inc = (play_seq_r == 32'hFFFF_FFFF || play_slot_r == SW'(SLOTS - 1)) ?
                         '0 : SW'(play_slot_r + 1'b1);

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{frame: RST_FRAME, min_delay: RST_MIN, max_delay: RST_MAX, hold: RST_HOLD};
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME: cfg_r.frame     <= cfg_data;
        REG_MIN:   cfg_r.min_delay <= cfg_data;
        REG_MAX:   cfg_r.max_delay <= cfg_data;
        REG_HOLD:  cfg_r.hold      <= cfg_data;
        default:   cfg_r.frame     <= cfg_r.frame;
      endcase
    end
  end

  always_comb begin
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_re = 1'b0; s_ra = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0; n_re = 1'b0; n_ra = '0;
    div_start = 1'b0; div_a = '0; div_b = '0;
    case (state_r)
      ST_CLR: begin
        s_we = 1'b1;
        s_wa = clr_a_r;
      end
      ST_PRD: begin
        s_re = 1'b1;
        s_ra = slot_r;
      end
      ST_PCHK: begin
        s_we = !too_big && !late && !coll;
        s_wa = slot_r;
        s_wd = {1'b1, in_r.seq, in_r.length[LEN_W-1:0]};
      end
      ST_FRM: begin
        div_start = 1'b1;
        div_a = DIV_AW'(delay_target_r);
        div_b = cfg_r.frame;
      end
      ST_SCAN: begin
        s_re = 1'b1;
        s_ra = scan_a_r;
      end
      ST_LRD: begin
        s_re = 1'b1;
        s_ra = play_slot_r;
      end
      ST_LCHK: begin
        s_we = hit;
        s_wa = play_slot_r;
        s_wd = {1'b0, q_seq, q_len};
        n_we = !hit && (nack_fill_r < NFW'(NACK_DEPTH));
        n_wa = nack_fill_r[NIW-1:0];
        n_wd = play_seq_r;
      end
      ST_DRD: begin
        n_re = 1'b1;
        n_ra = dr_i_r[NIW-1:0];
      end
      default: s_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLR;
      clr_a_r        <= '0;
      clr_emit_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      playing_r      <= 1'b0;
      play_seq_r     <= '0;
      play_slot_r    <= '0;
      delay_target_r <= RST_MIN;
      jitter_r       <= '0;
      prev_arrival_r <= '0;
      prev_transit_r <= '0;
      nack_fill_r    <= '0;
      lost_run_r     <= '0;
      stable_run_r   <= '0;
      scan_dv_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            in_r <= in_data;
            res_slot_r <= '0;
            res_len_r  <= '0;
            res_seq_r  <= '0;
            case (in_data.action)
              ACT_PUSH: begin
                slot_r  <= in_data.seq[SW-1:0];
                state_r <= ST_PRD;
              end
              ACT_PULL: begin
                if (playing_r) begin
                  state_r <= ST_LRD;
                end else begin
                  res_status_r <= STS_EMPTY;
                  state_r <= ST_EMIT;
                end
              end
              ACT_DRAIN: begin
                if (in_data.max_count != 8'd0) begin
                  nack_fill_r <= '0;
                  dr_n_r <= NFW'(drain_n);
                  dr_i_r <= '0;
                  if (drain_n != 8'd0) begin
                    state_r <= ST_DRD;
                  end
                end
              end
              default: begin
                playing_r      <= 1'b0;
                play_seq_r     <= '0;
                play_slot_r    <= '0;
                delay_target_r <= cfg_r.min_delay;
                jitter_r       <= '0;
                prev_arrival_r <= '0;
                prev_transit_r <= '0;
                nack_fill_r    <= '0;
                lost_run_r     <= '0;
                stable_run_r   <= '0;
                clr_a_r        <= '0;
                clr_emit_r     <= 1'b1;
                state_r        <= ST_CLR;
              end
            endcase
          end
        end
        ST_CLR: begin
          clr_a_r <= SW'(clr_a_r + 1'b1);
          if (clr_a_r == SW'(SLOTS - 1)) begin
            clr_emit_r <= 1'b0;
            res_status_r <= STS_OK;
            state_r <= clr_emit_r ? ST_EMIT : ST_IDLE;
          end
        end
        ST_PRD: state_r <= ST_PCHK;
        ST_PCHK: begin
          res_slot_r <= slot_r;
          res_seq_r  <= in_r.seq;
          if (too_big) begin
            res_status_r <= STS_FULL;
            state_r <= ST_EMIT;
          end else if (late) begin
            res_status_r <= STS_LATE;
            state_r <= ST_EMIT;
          end else if (coll) begin
            res_status_r <= STS_FULL;
            state_r <= ST_EMIT;
          end else begin
            res_status_r <= STS_OK;
            state_r <= ST_JIT;
          end
        end
        ST_JIT: begin
          if (prev_arrival_r != 32'd0) begin
            jitter_r <= est.jitter_nxt;
          end
          prev_transit_r <= transit;
          prev_arrival_r <= in_r.arrival_time;
          state_r <= ST_DLY;
        end
        ST_DLY: begin
          delay_target_r <= est.target_nxt;
          stable_run_r   <= est.stable_nxt;
          scan_a_r  <= '0;
          scan_dv_r <= 1'b0;
          depth_r   <= '0;
          any_r     <= 1'b0;
          frames_r  <= '0;
          if (playing_r) begin
            state_r <= ST_EMIT;
          end else if (cfg_r.frame == 16'd0) begin
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_FRM;
          end
        end
        ST_FRM: state_r <= ST_FRMW;
        ST_FRMW: begin
          if (div_done) begin
            frames_r <= div_q[15:0];
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN, ST_SEND: begin
          if (scan_dv_r) begin
            if (q_used && q_seq >= play_seq_r) begin
              depth_r <= CNW'(depth_r + 1'b1);
            end
            if (q_used && (!any_r || q_seq < lo_r)) begin
              lo_r <= q_seq;
              lo_slot_r <= scan_di_r;
              any_r <= 1'b1;
            end
          end
          scan_dv_r <= (state_r == ST_SCAN);
          scan_di_r <= scan_a_r;
          if (state_r == ST_SEND) begin
            state_r <= ST_START;
          end else if (scan_a_r == SW'(SLOTS - 1)) begin
            state_r <= ST_SEND;
          end else begin
            scan_a_r <= SW'(scan_a_r + 1'b1);
          end
        end
        ST_START: begin
          if (32'(depth_r) >= 32'(frames_r)) begin
            playing_r <= 1'b1;
            if (any_r) begin
              play_seq_r  <= lo_r;
              play_slot_r <= lo_slot_r;
            end
          end
          state_r <= ST_EMIT;
        end
        ST_LRD: state_r <= ST_LCHK;
        ST_LCHK: begin
          res_slot_r <= play_slot_r;
          res_seq_r  <= play_seq_r;
          if (hit) begin
            res_status_r <= STS_OK;
            res_len_r    <= q_len;
            lost_run_r   <= '0;
          end else begin
            res_status_r <= STS_LOST;
            if (nack_fill_r < NFW'(NACK_DEPTH)) begin
              nack_fill_r <= NFW'(nack_fill_r + 1'b1);
            end
            if (lost_run_r != 16'hFFFF) begin
              lost_run_r <= 16'(lost_run_r + 1'b1);
            end
          end
          play_seq_r  <= play_seq_inc;
          play_slot_r <= play_slot_inc;
          state_r <= ST_EMIT;
        end
        ST_DRD: state_r <= ST_DEM;
        ST_DEM: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_r.status       <= STS_OK;
            out_r.slot_index   <= '0;
            out_r.out_length   <= '0;
            out_r.out_seq      <= n_rd;
            out_r.jitter_int   <= jitter_r[31:16];
            out_r.target_delay <= delay_target_r;
            out_r.burst_loss   <= lost_run_r >= 16'd2;
            out_r.last         <= (dr_i_r == NFW'(dr_n_r - 1'b1));
            if (dr_i_r == NFW'(dr_n_r - 1'b1)) begin
              state_r <= ST_IDLE;
            end else begin
              dr_i_r <= NFW'(dr_i_r + 1'b1);
              state_r <= ST_DRD;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_r.status       <= res_status_r;
            out_r.slot_index   <= res_slot16[SLOT_IDX_W-1:0];
            out_r.out_length   <= res_len_r;
            out_r.out_seq      <= res_seq_r;
            out_r.jitter_int   <= jitter_r[31:16];
            out_r.target_delay <= delay_target_r;
            out_r.burst_loss   <= lost_run_r >= 16'd2;
            out_r.last         <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  ajb_ram #(.DEPTH(SLOTS), .WIDTH(MW), .AW(SW)) u_slot_ram (
    .clk(clk), .we(s_we), .wa(s_wa), .wd(s_wd), .re(s_re), .ra(s_ra), .rd(s_rd)
  );

  ajb_ram #(.DEPTH(NACK_DEPTH), .WIDTH(32), .AW(NIW)) u_nack_ram (
    .clk(clk), .we(n_we), .wa(n_wa), .wd(n_wd), .re(n_re), .ra(n_ra), .rd(n_rd)
  );

  ajb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quot(div_q)
  );

  ajb_est u_est (
    .cfg(cfg_r), .jitter(jitter_r), .transit(transit), .prev_transit(prev_transit_r),
    .target(delay_target_r), .stable(stable_run_r), .est(est)
  );

  `AJB_ASSERT(a_nack_fill_bound, nack_fill_r <= NFW'(NACK_DEPTH), "NACK fill past depth")
  `AJB_ASSERT(a_play_start, $rose(playing_r) |-> $past(state_r == ST_START), "playout start outside scan end")
  `AJB_ASSERT(a_div_idle_start, div_start |-> !div_busy, "divider restarted while busy")
  `AJB_ASSERT(a_play_slot_range, play_slot_r <= SW'(SLOTS - 1), "play slot out of range")
  `AJB_ASSERT_ALWAYS(a_no_accept_in_reset, !rst_n |=> !in_ready, "input accepted during clearing pass")

endmodule

// ----- rtl/core/ajb_ram.sv -----
// Single-port-write, registered-read synchronous RAM
module ajb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

// ----- rtl/core/ajb_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle
module ajb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ajb_pkg::DIV_AW-1:0] dividend,
  input  logic [ajb_pkg::DIV_BW-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [ajb_pkg::DIV_AW-1:0] quot
);
  import ajb_pkg::*;

  localparam int CW = $clog2(DIV_AW);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [DIV_AW-1:0] q_r;
  logic [DIV_BW-1:0] r_r;
  logic [DIV_BW-1:0] d_r;
  logic [DIV_BW:0]   rs;
  logic              ge;

  assign rs = {r_r, q_r[DIV_AW-1]};
  assign ge = rs >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        q_r <= {q_r[DIV_AW-2:0], ge};
        r_r <= ge ? DIV_BW'(rs - {1'b0, d_r}) : rs[DIV_BW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_AW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- rtl/core/ajb_est.sv -----
// Jitter estimate and target delay update arithmetic
module ajb_est (
  input  ajb_pkg::cfg_t  cfg,
  input  logic [31:0]    jitter,
  input  logic [31:0]    transit,
  input  logic [31:0]    prev_transit,
  input  logic [15:0]    target,
  input  logic [15:0]    stable,
  output ajb_pkg::est_t  est
);
  import ajb_pkg::*;

  logic [31:0]        d;
  logic [31:0]        mag32;
  logic [15:0]        mag;
  logic signed [33:0] delta;
  logic signed [33:0] step;
  logic [18:0]        sum;
  logic [15:0]        sum_sat;
  logic [15:0]        ideal_a;
  logic [15:0]        ideal;
  logic [15:0]        stable_inc;
  logic [16:0]        floor_v;

  always_comb begin
    d     = transit - prev_transit;
    mag32 = d[31] ? (32'd0 - d) : d;
    mag   = (mag32 > 32'd65535) ? 16'hFFFF : mag32[15:0];
    delta = $signed({2'b00, mag, 16'h0000}) - $signed({2'b00, jitter});
    step  = delta[33] ? ((delta + 34'sd15) >>> 4) : (delta >>> 4);
    est.jitter_nxt = 32'(jitter + step[31:0]);

    sum     = {1'b0, jitter[31:16], 2'b00} + {3'b000, cfg.frame};
    sum_sat = (sum > 19'd65535) ? 16'hFFFF : sum[15:0];
    ideal_a = (sum_sat < cfg.max_delay) ? sum_sat : cfg.max_delay;
    ideal   = (ideal_a < cfg.min_delay) ? cfg.min_delay : ideal_a;
    stable_inc = (stable == 16'hFFFF) ? stable : 16'(stable + 1'b1);
    floor_v = {1'b0, cfg.min_delay} + {1'b0, cfg.frame};

    est.target_nxt = target;
    est.stable_nxt = stable_inc;
    if (ideal > target) begin
      est.target_nxt = ideal;
      est.stable_nxt = '0;
    end else if (ideal < target && stable_inc >= cfg.hold) begin
      est.target_nxt = ({1'b0, target} > floor_v) ? 16'(target - cfg.frame) : cfg.min_delay;
      est.stable_nxt = '0;
    end
  end

endmodule

// ----- tb/tb_adaptive_jitter_buffer.sv -----
// Self-checking testbench for the adaptive jitter buffer: directed table, random traffic, config sweep
`timescale 1ns / 1ps
module tb_adaptive_jitter_buffer;
  import ajb_pkg::*;

  localparam int SLOTS       = 64;
  localparam int MAX_PAYLOAD = 1500;
  localparam int NACK_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  adaptive_jitter_buffer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_result(out_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // buffer model state
  logic [15:0] frame_ms, min_ms, max_ms, hold_cnt;
  bit          slot_used [SLOTS];
  logic [31:0] slot_seq [SLOTS];
  logic [10:0] slot_len [SLOTS];
  logic [31:0] play_seq;
  bit          playing;
  logic [15:0] delay_target;
  logic [31:0] jitter_q16, prev_arrival, prev_transit;
  logic [31:0] lost_seqs [NACK_DEPTH];
  int unsigned nack_fill;
  logic [15:0] lost_run, stable_run;

  out_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned action_cnt [4];
  longint cycles = 0;

  function automatic void clear_buffer();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    play_seq = '0;
    playing = 1'b0;
    delay_target = min_ms;
    jitter_q16 = '0;
    prev_arrival = '0;
    prev_transit = '0;
    nack_fill = 0;
    lost_run = '0;
    stable_run = '0;
  endfunction

  function automatic out_t make_result(status_t st, logic [5:0] slot, logic [10:0] len,
                                       logic [31:0] seq);
    out_t r;
    r.status = st;
    r.slot_index = slot;
    r.out_length = len;
    r.out_seq = seq;
    r.jitter_int = jitter_q16[31:16];
    r.target_delay = delay_target;
    r.burst_loss = (lost_run >= 2);
    r.last = 1'b0;
    return r;
  endfunction

  function automatic status_t store_packet(in_t c);
    logic [5:0] s;
    logic [31:0] transit, d, mag, lo;
    longint delta;
    int unsigned sum, ideal, frames, depth;
    bit any;
    s = c.seq[5:0];
    if (c.length > MAX_PAYLOAD) return STS_FULL;
    if (playing && c.seq < play_seq) return STS_LATE;
    if (slot_used[s] && slot_seq[s] != c.seq && slot_seq[s] >= play_seq) return STS_FULL;
    slot_used[s] = 1'b1;
    slot_seq[s] = c.seq;
    slot_len[s] = c.length[10:0];
    transit = c.arrival_time - c.media_time;
    if (prev_arrival != 0) begin
      d = transit - prev_transit;
      mag = d[31] ? -d : d;
      if (mag > 65535) mag = 65535;
      delta = (longint'(mag) <<< 16) - longint'(jitter_q16);
      jitter_q16 = 32'(longint'(jitter_q16) + delta / 16);
    end
    prev_transit = transit;
    prev_arrival = c.arrival_time;
    sum = int'(jitter_q16[31:16]) * 4 + frame_ms;
    if (sum > 65535) sum = 65535;
    ideal = (sum < max_ms) ? sum : max_ms;
    if (ideal < min_ms) ideal = min_ms;
    if (ideal > delay_target) begin
      delay_target = ideal[15:0];
      stable_run = '0;
    end else begin
      if (stable_run != 16'hFFFF) stable_run++;
      if (ideal < delay_target && stable_run >= hold_cnt) begin
        if (int'(delay_target) > int'(min_ms) + int'(frame_ms))
          delay_target = delay_target - frame_ms;
        else
          delay_target = min_ms;
        stable_run = '0;
      end
    end
    if (!playing) begin
      frames = (frame_ms != 0) ? delay_target / frame_ms : 0;
      depth = 0;
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && slot_seq[i] >= play_seq) depth++;
      if (depth >= frames) begin
        any = 1'b0;
        lo = '0;
        playing = 1'b1;
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && (!any || slot_seq[i] < lo)) begin
            lo = slot_seq[i];
            any = 1'b1;
          end
        if (any) play_seq = lo;
      end
    end
    return STS_OK;
  endfunction

  function automatic void predict_results(in_t c);
    out_t r;
    status_t st;
    logic [5:0] s;
    logic [31:0] cur;
    int unsigned n;
    case (c.action)
      ACT_PUSH: begin
        st = store_packet(c);
        r = make_result(st, c.seq[5:0], '0, c.seq);
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      ACT_PULL: begin
        if (!playing) begin
          r = make_result(STS_EMPTY, '0, '0, '0);
        end else begin
          s = play_seq[5:0];
          cur = play_seq;
          play_seq = play_seq + 1;
          if (slot_used[s] && slot_seq[s] == cur) begin
            slot_used[s] = 1'b0;
            lost_run = '0;
            r = make_result(STS_OK, s, slot_len[s], cur);
          end else begin
            if (nack_fill < NACK_DEPTH) lost_seqs[nack_fill++] = cur;
            if (lost_run != 16'hFFFF) lost_run++;
            r = make_result(STS_LOST, s, '0, cur);
          end
        end
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      ACT_DRAIN: begin
        if (c.max_count != 0) begin
          n = (nack_fill < c.max_count) ? nack_fill : c.max_count;
          nack_fill = 0;
          for (int i = 0; i < n; i++) begin
            r = make_result(STS_OK, '0, '0, lost_seqs[i]);
            r.last = (i == n - 1);
            expected_results.push_back(r);
          end
        end
      end
      default: begin
        clear_buffer();
        r = make_result(STS_OK, '0, '0, '0);
        r.last = 1'b1;
        expected_results.push_back(r);
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", out_result);
      end else begin
        if (out_result.status !== expected_results[0].status ||
            out_result.slot_index !== expected_results[0].slot_index ||
            out_result.out_length !== expected_results[0].out_length ||
            out_result.out_seq !== expected_results[0].out_seq ||
            out_result.jitter_int !== expected_results[0].jitter_int ||
            out_result.target_delay !== expected_results[0].target_delay ||
            out_result.burst_loss !== expected_results[0].burst_loss ||
            out_result.last !== expected_results[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d\n  exp %p\n  got %p", results_seen,
                     expected_results[0], out_result);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // receiver stalls in changing modes
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycles % 8) < 5;
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  int unsigned burst_left = 0;

  task automatic send_item(in_t c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    action_cnt[c.action]++;
    predict_results(c);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] fr, logic [15:0] mn, logic [15:0] mx,
                              logic [15:0] hd);
    logic [15:0] vals [4];
    vals = '{fr, mn, mx, hd};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    frame_ms = fr;
    min_ms = mn;
    max_ms = mx;
    hold_cnt = hd;
  endtask

  // random traffic state
  logic [31:0] seq_cursor = 0;
  logic [31:0] media_base = 0;
  logic [31:0] arrive_base = 1000;

  function automatic in_t random_item();
    in_t c;
    int unsigned r;
    c.action = ACT_PUSH;
    c.seq = $urandom();
    c.media_time = $urandom();
    c.length = $urandom_range(0, 65535);
    c.arrival_time = $urandom();
    c.max_count = $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      c.seq = seq_cursor;
      case ($urandom_range(0, 9))
        0: c.seq = seq_cursor + $urandom_range(1, 4);
        1: c.seq = seq_cursor - $urandom_range(1, 3);
        2: c.seq = seq_cursor + 64;
        default: ;
      endcase
      seq_cursor = seq_cursor + 1;
      media_base = media_base + 20;
      arrive_base = arrive_base + 20;
      c.media_time = media_base;
      c.arrival_time = arrive_base + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 400)
                                                                 : $urandom_range(0, 15));
      if ($urandom_range(0, 19) != 0) c.length = $urandom_range(0, MAX_PAYLOAD);
    end else if (r < 83) begin
      c.action = ACT_PULL;
    end else if (r < 91) begin
      c.action = ACT_DRAIN;
      if ($urandom_range(0, 2) != 0) c.max_count = $urandom_range(1, 20);
    end else if (r < 94) begin
      c.action = ACT_RESTART;
      case ($urandom_range(0, 2))
        0: seq_cursor = $urandom_range(0, 100);
        1: seq_cursor = 32'hFFFFFFFF - $urandom_range(0, 60);
        default: seq_cursor = $urandom();
      endcase
    end else begin
      c.action = action_t'($urandom_range(0, 3));
      if (c.action == ACT_RESTART) seq_cursor = $urandom();
    end
    return c;
  endfunction

  typedef struct {
    in_t  item;
    bit   typed;
    out_t result;
  } stim_row_t;

  function automatic in_t cmd(action_t a, logic [31:0] sq, logic [31:0] mt,
                              logic [15:0] ln, logic [31:0] at, logic [7:0] mc);
    in_t c;
    c = '{a, sq, mt, ln, at, mc};
    return c;
  endfunction

  stim_row_t directed [$];

  initial begin
    frame_ms = RST_FRAME;
    min_ms = RST_MIN;
    max_ms = RST_MAX;
    hold_cnt = RST_HOLD;
    clear_buffer();
    directed = '{
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 1,
        '{STS_EMPTY, 6'd0, 11'd0, 32'd0, 16'd0, 16'd20, 1'b0, 1'b1}},
      '{cmd(ACT_DRAIN, 0, 0, 0, 0, 0), 0, '0},
      '{cmd(ACT_PUSH, 5, 0, 16'hFFFF, 9, 0), 1,
        '{STS_FULL, 6'd5, 11'd0, 32'd5, 16'd0, 16'd20, 1'b0, 1'b1}},
      '{cmd(ACT_PUSH, 0, 0, 0, 100, 0), 0, '0},
      '{cmd(ACT_PUSH, 1, 20, 1500, 32'hFFFFFFFF, 0), 0, '0},
      '{cmd(ACT_PUSH, 65, 40, 10, 160, 0), 0, '0},
      '{cmd(ACT_PUSH, 2, 32'hFFFFFFFF, 1501, 170, 0), 0, '0},
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 0, '0},
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 0, '0},
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 0, '0},
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 0, '0},
      '{cmd(ACT_PUSH, 1, 20, 100, 200, 0), 0, '0},
      '{cmd(ACT_PUSH, 68, 80, 700, 210, 0), 0, '0},
      '{cmd(ACT_PUSH, 4, 60, 300, 205, 0), 0, '0},
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 0, '0},
      '{cmd(ACT_DRAIN, 0, 0, 0, 0, 1), 0, '0},
      '{cmd(ACT_DRAIN, 0, 0, 0, 0, 8'hFF), 0, '0},
      '{cmd(ACT_PUSH, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0), 0, '0},
      '{cmd(ACT_RESTART, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF), 1,
        '{STS_OK, 6'd0, 11'd0, 32'd0, 16'd0, 16'd20, 1'b0, 1'b1}},
      '{cmd(ACT_PUSH, 32'hFFFFFFFE, 32'hAAAAAAAA, 16'h5555, 32'h55555555, 8'hAA), 0, '0},
      '{cmd(ACT_PUSH, 32'hFFFFFFFF, 32'hAAAAAABE, 1024, 32'h55555569, 8'h55), 0, '0},
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 0, '0},
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 0, '0},
      '{cmd(ACT_PULL, 0, 0, 0, 0, 0), 0, '0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_config(RST_FRAME, RST_MIN, RST_MAX, RST_HOLD);

    foreach (directed[i]) begin
      send_item(directed[i].item);
      if (directed[i].typed) expected_results[expected_results.size() - 1] = directed[i].result;
    end
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_config(RST_FRAME, RST_MIN, RST_MAX, RST_HOLD);
        1: write_config(16'd1, 16'd0, 16'hFFFF, 16'd1);
        2: write_config(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        3: write_config(16'd0, 16'd5, 16'd60, 16'd3);
        default: write_config(16'd10, 16'd30, 16'd120, 16'd4);
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
        send_item(random_item());
        if (phase == 1 && k == 40) wait_drained();
      end
      wait_drained();
    end

    $display("covered %0d transfers in (push %0d, pull %0d, drain %0d, restart %0d)",
             items_sent, action_cnt[0], action_cnt[1], action_cnt[2], action_cnt[3]);
    $display("%0d results checked over 5 register settings, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
